// File: hdl/scl2x_pkg.sv
// shared types and constants for the scale2x pixel upscaler
// no dependencies; imported by every module of the block

package scl2x_pkg;

	// geometry of the line stores and field widths
	localparam int MaxWidth   = 1024;
	localparam int ColW       = $clog2(MaxWidth);
	localparam int PixW       = 32;
	localparam int RowW       = 12;
	localparam int WidthRegW  = 11;
	localparam int HeightRegW = 12;
	localparam int CfgDataW   = 12;

	// register reset values
	localparam logic [WidthRegW-1:0]  FrameWidthReset  = 11'd1024;
	localparam logic [HeightRegW-1:0] FrameHeightReset = 12'd768;

	typedef logic [PixW-1:0]     pixel_t;
	typedef logic [ColW-1:0]     col_t;
	typedef logic [RowW-1:0]     row_t;
	typedef logic [CfgDataW-1:0] cfg_data_t;

	// input word kinds
	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_DRAIN = 1'b1
	} opcode_t;

	// configuration register indexes
	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_idx_t;

	// input word
	typedef struct packed {
		opcode_t opcode;
		pixel_t  pixel_in;
	} in_word_t;

	// output word
	typedef struct packed {
		pixel_t top_left;
		pixel_t top_right;
		pixel_t bottom_left;
		pixel_t bottom_right;
		row_t   src_row;
		col_t   src_col;
		logic   frame_last;
	} out_word_t;

	// per-word job handed from the sequencer to the blend stage
	typedef struct packed {
		logic emit;
		logic has_above;
		logic use_left;
		logic use_right;
		logic drain;
		logic last;
		row_t row;
		col_t col;
	} job_t;

	// line store read data as seen by the blend stage
	typedef struct packed {
		pixel_t e;
		pixel_t f;
		pixel_t b;
	} rd_t;

	// write-back into the older line store
	typedef struct packed {
		logic   wr;
		col_t   col;
		pixel_t data;
	} wb_t;

	// blend stage flow status
	typedef struct packed {
		logic ready;
		logic adv;
	} kern_st_t;

endpackage

// File: hdl/scl2x_ctrl.sv
// raster sequencer: configuration registers, column/row counters, drain phase
// depends on scl2x_pkg

module scl2x_ctrl import scl2x_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  cfg_idx_t  cfg_index,
	input  cfg_data_t cfg_data,
	input  logic      take,
	input  opcode_t   opcode,
	output logic      go,
	output job_t      job
);

	logic [WidthRegW-1:0]  frame_width_q;
	logic [WidthRegW-1:0]  w_eff;
	logic [HeightRegW-1:0] frame_height_q;
	logic [HeightRegW-1:0] h_eff;
	col_t                  in_col_q;
	row_t                  in_row_q;
	logic                  draining_q;
	logic                  row_end;
	logic                  frame_end;
	logic [RowW:0]         row_inc;

	// effective geometry with out-of-range values clamped
	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = WidthRegW'(1);
		end else if (frame_width_q > WidthRegW'(MaxWidth)) begin
			w_eff = WidthRegW'(MaxWidth);
		end else begin
			w_eff = frame_width_q;
		end
		h_eff = (frame_height_q == '0) ? HeightRegW'(1) : frame_height_q;
	end

	// row and frame end detection
	assign row_end   = (WidthRegW'(in_col_q) + WidthRegW'(1)) >= w_eff;
	assign row_inc   = {1'b0, in_row_q} + {{RowW{1'b0}}, 1'b1};
	assign frame_end = row_inc >= {1'b0, h_eff};

	// word kind must match the phase, otherwise it is dropped
	assign go = take && (opcode == (draining_q ? OP_DRAIN : OP_PIXEL));

	// job description for the word being taken
	always_comb begin
		job.emit      = draining_q || (in_row_q != '0);
		job.has_above = draining_q ? (in_row_q != '0) : (in_row_q > RowW'(1));
		job.use_left  = in_col_q != '0;
		job.use_right = !row_end;
		job.drain     = draining_q;
		job.last      = draining_q && row_end;
		job.row       = draining_q ? in_row_q : in_row_q - RowW'(1);
		job.col       = in_col_q;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FrameWidthReset;
			frame_height_q <= FrameHeightReset;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[WidthRegW-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[HeightRegW-1:0];
				default: ;
			endcase
		end
	end

	// raster position and drain phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			draining_q <= 1'b0;
		end else if (go) begin
			if (row_end) begin
				in_col_q <= '0;
				if (draining_q) begin
					in_row_q   <= '0;
					draining_q <= 1'b0;
				end else if (frame_end) begin
					draining_q <= 1'b1;
				end else begin
					in_row_q <= row_inc[RowW-1:0];
				end
			end else begin
				in_col_q <= in_col_q + ColW'(1);
			end
		end
	end

endmodule

// File: hdl/scl2x_line_stores.sv
// the two line stores: newest row (two reads, one write) and the row before it
// (one read, one write) with forwarding of a same-column write-back; uses scl2x_pkg

module scl2x_line_stores import scl2x_pkg::*; (
	input  logic   clk,
	input  logic   go,
	input  job_t   job,
	input  pixel_t pix,
	input  wb_t    wb,
	output rd_t    rd
);

	pixel_t r1_mem [MaxWidth];
	pixel_t r2_mem [MaxWidth];
	pixel_t rd_e_q;
	pixel_t rd_f_q;
	pixel_t rd_b_q;
	pixel_t fwd_data_q;
	logic   fwd_q;
	col_t   right_col;

	assign right_col = job.col + ColW'(1);

	// newest row: centre and right neighbour read, new pixel written
	always_ff @(posedge clk) begin
		if (go) begin
			if (!job.drain) begin
				r1_mem[job.col] <= pix;
			end
			rd_e_q <= r1_mem[job.col];
			rd_f_q <= r1_mem[right_col];
		end
	end

	// older row: pixel above read, centre of the finished word written back
	always_ff @(posedge clk) begin
		if (wb.wr) begin
			r2_mem[wb.col] <= wb.data;
		end
		if (go) begin
			rd_b_q     <= r2_mem[job.col];
			fwd_q      <= wb.wr && (wb.col == job.col);
			fwd_data_q <= wb.data;
		end
	end

	// read data, write-back in the same cycle wins
	assign rd.e = rd_e_q;
	assign rd.f = rd_f_q;
	assign rd.b = fwd_q ? fwd_data_q : rd_b_q;

endmodule

// File: hdl/scl2x_kernel.sv
// blend stage: neighbour selection, scale2x rules and the output register
// depends on scl2x_pkg; read data comes from scl2x_line_stores

module scl2x_kernel import scl2x_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      go,
	input  job_t      job,
	input  pixel_t    pix,
	input  rd_t       rd,
	input  logic      out_stall,
	output wb_t       wb,
	output kern_st_t  st,
	output logic      out_valid,
	output out_word_t out_word
);

	logic      s1_valid_q;
	job_t      job_s1;
	pixel_t    pix_s1;
	pixel_t    prev_e_q;
	logic      out_valid_q;
	out_word_t out_word_q;
	logic      adv;
	pixel_t    e;
	pixel_t    b;
	pixel_t    d;
	pixel_t    f;
	pixel_t    h;
	pixel_t    tl;
	pixel_t    tr;
	pixel_t    bl;
	pixel_t    br;

	// stage moves on unless its word needs a full, stalled output register
	assign adv      = s1_valid_q && (!job_s1.emit || !out_valid_q || !out_stall);
	assign st.adv   = adv;
	assign st.ready = !s1_valid_q || adv;

	// neighbours, edge pixels replaced by the centre
	always_comb begin
		e = rd.e;
		b = job_s1.has_above ? rd.b : e;
		f = job_s1.use_right ? rd.f : e;
		d = job_s1.use_left ? prev_e_q : e;
		h = job_s1.drain ? e : pix_s1;
	end

	// scale2x rules
	always_comb begin
		tl = e;
		tr = e;
		bl = e;
		br = e;
		if ((b != h) && (d != f)) begin
			if (d == b) tl = d;
			if (b == f) tr = f;
			if (d == h) bl = d;
			if (h == f) br = f;
		end
	end

	// centre goes back to the older line store as the stage moves on
	assign wb.wr   = adv;
	assign wb.col  = job_s1.col;
	assign wb.data = e;

	// stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (go) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// stage payload and left-neighbour register
	always_ff @(posedge clk) begin
		if (go) begin
			job_s1 <= job;
			pix_s1 <= pix;
		end
		if (adv) begin
			prev_e_q <= e;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && job_s1.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (adv && job_s1.emit) begin
			out_word_q.top_left     <= tl;
			out_word_q.top_right    <= tr;
			out_word_q.bottom_left  <= bl;
			out_word_q.bottom_right <= br;
			out_word_q.src_row      <= job_s1.row;
			out_word_q.src_col      <= job_s1.col;
			out_word_q.frame_last   <= job_s1.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

// File: hdl/scale2x_pixel_upscaler.sv
// top level of the scale2x pixel upscaler
// depends on scl2x_pkg, scl2x_ctrl, scl2x_line_stores, scl2x_kernel

// Streams a frame of 32-bit pixels in raster order and returns one 2x2
// scale2x block per source pixel. The block of row r, column c leaves when
// pixel (r+1, c) is taken; after the last row, frame_width drain words
// (opcode 1) flush the final row. Words of the wrong kind for the current
// phase are taken and dropped. Unless stalled, the block takes one word per
// clock: each word makes one pass through the newest-row store (two reads and
// one write in the cycle it is taken) and the older-row store (one read, and a
// write-back as the blend stage moves the word on, forwarded when the next
// word hits the same column). A result enters the output register as the
// blend stage moves its word on; the input stalls only while the blend stage
// holds a word behind a full, stalled output register. Both line stores are
// 1024 x 32 and start out unwritten: no clearing pass, the block is ready right
// after reset. Write frame_width and frame_height only while the block is idle.

module scale2x_pixel_upscaler import scl2x_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  cfg_idx_t  cfg_index,
	input  cfg_data_t cfg_data,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word
);

	logic     take;
	logic     go;
	job_t     job_w;
	rd_t      rd_w;
	wb_t      wb_w;
	kern_st_t st_w;

	assign in_stall = !st_w.ready;
	assign take     = in_valid && !in_stall;

	// raster sequencer
	scl2x_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.opcode    (in_word.opcode),
		.go        (go),
		.job       (job_w)
	);

	// line stores
	scl2x_line_stores u_stores (
		.clk (clk),
		.go  (go),
		.job (job_w),
		.pix (in_word.pixel_in),
		.wb  (wb_w),
		.rd  (rd_w)
	);

	// blend stage and output register
	scl2x_kernel u_kernel (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.job       (job_w),
		.pix       (in_word.pixel_in),
		.rd        (rd_w),
		.out_stall (out_stall),
		.wb        (wb_w),
		.st        (st_w),
		.out_valid (out_valid),
		.out_word  (out_word)
	);

	// a word is only worked on when its kind matches the phase
	a_kind_matches_phase: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> ((in_word.opcode == OP_DRAIN) == job_w.drain))
		else $error("word worked on in the wrong phase");

	// the last drain word returns the sequencer to the frame start
	a_drain_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(go && job_w.last) |=> (!job_w.drain && (job_w.col == '0)))
		else $error("sequencer did not restart after the final drain word");

	// a result only appears after the blend stage moved a word on
	a_out_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(st_w.adv))
		else $error("output valid rose without a blend stage advance");

endmodule
